// ===== rtl/sas_pkg.sv =====
// Shared types and constants for the servo angle smoother.
// Used by every module in rtl/; depends on nothing.
package sas_pkg;

  // Sample width and fixed-point precision of the smoothed angle.
  localparam int SAMPLE_BITS   = 10;
  localparam int FRACTION_BITS = 8;

  // Whole-degree angles and the fixed-point angle word.
  localparam int ANGLE_W   = 8;
  localparam int FIX_W     = ANGLE_W + FRACTION_BITS;
  localparam int ERR_W     = FIX_W + 1;
  localparam int GAIN_W    = 13;
  localparam int DBAND_W   = 16;
  localparam int GAIN_SHIFT = 12;
  localparam int PROD_W    = GAIN_W + 1 + ERR_W;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MAP_W     = SAMPLE_BITS + ANGLE_W;

  localparam logic [ANGLE_W-1:0]     ANGLE_MAX   = ANGLE_W'(180);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = {SAMPLE_BITS{1'b1}};
  localparam logic [FIX_W-1:0]       FIX_TOP     = {ANGLE_MAX, {FRACTION_BITS{1'b0}}};
  localparam logic [FIX_W:0]         FIX_HALF    = (FIX_W + 1)'(1) << (FRACTION_BITS - 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DBAND = CFG_IDX_W'(1);
  localparam logic [GAIN_W-1:0]    GAIN_RESET  = GAIN_W'(614);
  localparam logic [DBAND_W-1:0]   DBAND_RESET = DBAND_W'(256);

  // Target queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ERR,
    BK_MUL,
    BK_UPD
  } back_state_t;

endpackage

// ===== rtl/servo_angle_smoother.sv =====
// Servo angle smoother: one sample word in, one result word out.
// The back-end sequencer takes each word through pop, error, gain product and update,
// and holds in update while the previous result word is still unread.
// The front accepts while the back works.
// Reset (rst_n low, synchronous) empties the holding register, the queue and the result
// word, clears the filter state and loads gain 614 and deadband 256.
module servo_angle_smoother (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  logic [sas_pkg::SAMPLE_BITS-1:0]    in_raw_sample,
  output logic                               in_full,
  output logic                               out_empty,
  input  logic                               out_pop,
  output logic [sas_pkg::ANGLE_W-1:0]        out_target_angle,
  output logic [sas_pkg::ANGLE_W-1:0]        out_drive_angle,
  output logic                               out_drive_update,
  input  logic                               cfg_we,
  input  logic [sas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sas_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import sas_pkg::*;

  queue_stat_t        q_stat;
  logic               q_push;
  logic               q_pop;
  logic [ANGLE_W-1:0] q_wdata;
  logic [ANGLE_W-1:0] q_rdata;

  // Sample intake and angle mapping.
  sas_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_raw_sample (in_raw_sample),
    .in_full       (in_full),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_target      (q_wdata)
  );

  // Decoupling queue of target angles.
  sas_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Filter update and result word.
  sas_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .q_stat           (q_stat),
    .q_target         (q_rdata),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_target_angle (out_target_angle),
    .out_drive_angle  (out_drive_angle),
    .out_drive_update (out_drive_update)
  );

endmodule

// ===== rtl/sas_front.sv =====
// Front end: accepts samples and maps each to a whole-degree target angle.
// Depends on sas_pkg; feeds sas_queue.
module sas_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic [sas_pkg::SAMPLE_BITS-1:0] in_raw_sample,
  output logic                        in_full,
  input  sas_pkg::queue_stat_t        q_stat,
  output logic                        q_push,
  output logic [sas_pkg::ANGLE_W-1:0] q_target
);
  import sas_pkg::*;

  logic                   valid_r;
  logic [SAMPLE_BITS-1:0] raw_r;
  logic [MAP_W-1:0]       scaled;
  logic [ANGLE_W-1:0]     q_est;
  logic [MAP_W-1:0]       rem;
  logic                   accept;

  // The holding word leaves for the queue whenever the queue has room.
  assign q_push  = valid_r && !q_stat.full;
  assign in_full = valid_r && q_stat.full;
  assign accept  = in_push && !in_full;

  // Map raw*180/full: the estimate raw*180 >> SAMPLE_BITS is low by at most one,
  // so one compare of the remainder against full fixes it.
  always_comb begin
    scaled   = MAP_W'(raw_r) * MAP_W'(ANGLE_MAX);
    q_est    = scaled[MAP_W-1:SAMPLE_BITS];
    rem      = scaled - {q_est, {SAMPLE_BITS{1'b0}}} + MAP_W'(q_est);
    q_target = (rem >= MAP_W'(SAMPLE_FULL)) ? q_est + ANGLE_W'(1) : q_est;
  end

  // Holding register for one accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (q_push) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_r <= in_raw_sample;
    end
  end

endmodule

// ===== rtl/sas_queue.sv =====
// Short queue of target angles between the front and back ends.
// Depends on sas_pkg.
module sas_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [sas_pkg::ANGLE_W-1:0] wdata,
  input  logic                        pop,
  output logic [sas_pkg::ANGLE_W-1:0] rdata,
  output sas_pkg::queue_stat_t        stat
);
  import sas_pkg::*;

  logic [ANGLE_W-1:0] mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/sas_back.sv =====
// Back end: exponential moving-average update with deadband, clamp, rounding and
// change detection; holds the configuration and the result word.
// Depends on sas_pkg; reads targets from sas_queue.
module sas_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sas_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  sas_pkg::queue_stat_t           q_stat,
  input  logic [sas_pkg::ANGLE_W-1:0]    q_target,
  output logic                           q_pop,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [sas_pkg::ANGLE_W-1:0]    out_target_angle,
  output logic [sas_pkg::ANGLE_W-1:0]    out_drive_angle,
  output logic                           out_drive_update
);
  import sas_pkg::*;

  back_state_t state_r, state_nxt;

  logic [GAIN_W-1:0]      gain_r;
  logic [DBAND_W-1:0]     dband_r;
  logic [FIX_W-1:0]       smoothed_r;
  logic [ANGLE_W-1:0]     last_r;
  logic                   seeded_r;

  logic [ANGLE_W-1:0]     tgt_r;
  logic [FIX_W-1:0]       base_r;
  logic signed [ERR_W-1:0] err_r;
  logic                   apply_r;
  logic                   first_r;
  logic signed [PROD_W-1:0] prod_r;

  logic                   out_valid_r;
  logic [ANGLE_W-1:0]     out_target_r;
  logic [ANGLE_W-1:0]     out_drive_r;
  logic                   out_update_r;

  logic [FIX_W-1:0]       tgt_fix;
  logic [FIX_W-1:0]       base_nxt;
  logic signed [ERR_W-1:0] err_nxt;
  logic [ERR_W-1:0]       mag;
  logic signed [PROD_W-1:0] step;
  logic signed [SUM_W-1:0]  sum;
  logic [FIX_W-1:0]       clamped;
  logic [FIX_W:0]         rounded;
  logic [ANGLE_W-1:0]     drive;
  logic                   emit;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RESET;
      dband_r <= DBAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAIN:  gain_r  <= cfg_wdata[GAIN_W-1:0];
        CFG_DBAND: dband_r <= cfg_wdata[DBAND_W-1:0];
        default: ;
      endcase
    end
  end

  // Error stage: the first word seeds the smoothed angle with its target.
  always_comb begin
    tgt_fix  = {tgt_r, {FRACTION_BITS{1'b0}}};
    base_nxt = seeded_r ? smoothed_r : tgt_fix;
    err_nxt  = $signed({1'b0, tgt_fix}) - $signed({1'b0, base_nxt});
    mag      = err_nxt[ERR_W-1] ? ERR_W'(-err_nxt) : ERR_W'(err_nxt);
  end

  // Update stage: floor shift, add, clamp, round half up.
  always_comb begin
    step    = prod_r >>> GAIN_SHIFT;
    sum     = SUM_W'($signed({1'b0, base_r}));
    if (apply_r) begin
      sum = sum + SUM_W'(step);
    end
    if (sum < 0) begin
      clamped = '0;
    end else if (sum > $signed(SUM_W'(FIX_TOP))) begin
      clamped = FIX_TOP;
    end else begin
      clamped = sum[FIX_W-1:0];
    end
    rounded = {1'b0, clamped} + FIX_HALF;
    drive   = rounded[FRACTION_BITS +: ANGLE_W];
  end

  // Sequencer: each word passes the pop, error, product and update states; update waits until the result word is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          state_nxt = BK_ERR;
        end
      end
      BK_ERR: state_nxt = BK_MUL;
      BK_MUL: state_nxt = BK_UPD;
      BK_UPD: begin
        if (!out_valid_r || out_pop) begin
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      tgt_r <= q_target;
    end
    if (state_r == BK_ERR) begin
      base_r  <= base_nxt;
      err_r   <= err_nxt;
      apply_r <= (mag > ERR_W'(dband_r));
      first_r <= !seeded_r;
    end
    if (state_r == BK_MUL) begin
      prod_r <= PROD_W'($signed({1'b0, gain_r})) * PROD_W'(err_r);
    end
  end

  // Filter state, committed when the result word is written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r <= '0;
      last_r     <= '0;
      seeded_r   <= 1'b0;
    end else if (emit) begin
      smoothed_r <= clamped;
      last_r     <= drive;
      seeded_r   <= 1'b1;
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_target_r <= tgt_r;
      out_drive_r  <= drive;
      out_update_r <= first_r || (drive != last_r);
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_target_angle = out_target_r;
  assign out_drive_angle  = out_drive_r;
  assign out_drive_update = out_update_r;

endmodule

// ===== verif/servo_angle_smoother_checker.sv =====
`timescale 1ns / 100ps
// Checker for the servo angle smoother: watches the sample, result and register ports,
// predicts each result word and compares it field by field. Depends on rtl/sas_pkg.sv.
module servo_angle_smoother_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  logic                               in_full,
  input  logic [sas_pkg::SAMPLE_BITS-1:0]    in_raw_sample,
  input  logic                               out_empty,
  input  logic                               out_pop,
  input  logic [sas_pkg::ANGLE_W-1:0]        out_target_angle,
  input  logic [sas_pkg::ANGLE_W-1:0]        out_drive_angle,
  input  logic                               out_drive_update,
  input  logic                               cfg_we,
  input  logic [sas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sas_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                 mismatch_count,
  output int                                 words_pending,
  output int                                 words_checked,
  output int                                 update_count
);
  import sas_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ANGLE_W-1:0] target_angle;
    logic [ANGLE_W-1:0] drive_angle;
    logic               drive_update;
  } angle_word_t;

  // Filter state and register copies kept by the predictor.
  logic [FIX_W-1:0]   ema_angle;
  logic [ANGLE_W-1:0] sent_angle;
  logic               ema_seeded;
  logic [GAIN_W-1:0]  gain_reg;
  logic [DBAND_W-1:0] dband_reg;

  angle_word_t expected_angles[$];

  initial begin
    mismatch_count = 0;
    words_pending  = 0;
    words_checked  = 0;
    update_count   = 0;
  end

  // Map the sample, run one smoothing step and queue the word it should produce.
  task automatic predict_angles(input logic [SAMPLE_BITS-1:0] raw);
    int unsigned target;
    int          err;
    int unsigned mag;
    longint      next;
    logic [ANGLE_W-1:0] drive;
    angle_word_t word;
    target = (32'(raw) * 32'(ANGLE_MAX)) / 32'(SAMPLE_FULL);
    // The first sample after reset seeds the average, so the error starts at zero.
    if (!ema_seeded) begin
      ema_angle = FIX_W'(target << FRACTION_BITS);
    end
    err  = int'(target << FRACTION_BITS) - int'(ema_angle);
    mag  = (err < 0) ? -err : err;
    next = longint'(ema_angle);
    if (mag > dband_reg) begin
      // Arithmetic shift of the signed product rounds toward minus infinity.
      next = next + ((longint'(gain_reg) * err) >>> GAIN_SHIFT);
    end
    if (next < 0) begin
      next = 0;
    end else if (next > longint'(FIX_TOP)) begin
      next = longint'(FIX_TOP);
    end
    ema_angle = FIX_W'(next);
    drive = ANGLE_W'((next + (longint'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS);
    word.target_angle = ANGLE_W'(target);
    word.drive_angle  = drive;
    word.drive_update = !ema_seeded || (drive != sent_angle);
    sent_angle = drive;
    ema_seeded = 1'b1;
    expected_angles.push_back(word);
  endtask

  // Compare one popped result word with the oldest prediction.
  task automatic check_angles(input angle_word_t got);
    angle_word_t want;
    if (expected_angles.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("[%0t] unexpected result word: target %0d drive %0d update %0d",
                 $time, got.target_angle, got.drive_angle, got.drive_update);
      end
    end else begin
      want = expected_angles.pop_front();
      words_checked++;
      if (got.drive_update) begin
        update_count++;
      end
      if (got.target_angle !== want.target_angle || got.drive_angle !== want.drive_angle ||
          got.drive_update !== want.drive_update) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("[%0t] word %0d: target exp %0d got %0d,", $time, words_checked,
                   want.target_angle, got.target_angle,
                   " drive exp %0d got %0d, update exp %0d got %0d",
                   want.drive_angle, got.drive_angle, want.drive_update, got.drive_update);
        end
      end
    end
  endtask

  // Everything is sampled at the rising edge; results leave before new samples are predicted.
  always @(posedge clk) begin
    if (!rst_n) begin
      ema_angle  = '0;
      sent_angle = '0;
      ema_seeded = 1'b0;
      gain_reg   = GAIN_RESET;
      dband_reg  = DBAND_RESET;
      expected_angles.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GAIN) begin
          gain_reg = cfg_wdata[GAIN_W-1:0];
        end else if (cfg_index == CFG_DBAND) begin
          dband_reg = cfg_wdata[DBAND_W-1:0];
        end
      end
      if (out_pop && !out_empty) begin
        check_angles({out_target_angle, out_drive_angle, out_drive_update});
      end
      if (in_push && !in_full) begin
        predict_angles(in_raw_sample);
      end
    end
    words_pending = expected_angles.size();
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the servo angle smoother: clock, reset, sample and register stimulus,
// receiver stalls and the verdict. Depends on rtl/ and verif/servo_angle_smoother_checker.sv.
module tb;
  import sas_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int DRAIN_SLACK   = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int CHUNKS        = 5;
  localparam int CHUNK_ITEMS   = 60;
  localparam int PRESSURE_ITEMS = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);
  localparam logic [GAIN_W-1:0]    GAIN_TOP    = {GAIN_W{1'b1}};
  localparam logic [GAIN_W-1:0]    GAIN_UNITY  = GAIN_W'(4096);
  localparam logic [DBAND_W-1:0]   DBAND_TOP   = {DBAND_W{1'b1}};

  logic                   clk;
  logic                   rst_n;
  logic                   in_push;
  logic [SAMPLE_BITS-1:0] in_raw_sample;
  logic                   in_full;
  logic                   out_empty;
  logic                   out_pop;
  logic [ANGLE_W-1:0]     out_target_angle;
  logic [ANGLE_W-1:0]     out_drive_angle;
  logic                   out_drive_update;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int  mismatch_count;
  int  words_pending;
  int  words_checked;
  int  update_count;

  logic sample_taken = 1'b0;
  int   cycle_count  = 0;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   hold_req;
  int   hold_seen;
  int   hold_left;
  int   samples_sent;
  int   settings_used;
  int   prev_sample;

  servo_angle_smoother dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_raw_sample    (in_raw_sample),
    .in_full          (in_full),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_target_angle (out_target_angle),
    .out_drive_angle  (out_drive_angle),
    .out_drive_update (out_drive_update),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  servo_angle_smoother_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_raw_sample    (in_raw_sample),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_target_angle (out_target_angle),
    .out_drive_angle  (out_drive_angle),
    .out_drive_update (out_drive_update),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .words_pending    (words_pending),
    .words_checked    (words_checked),
    .update_count     (update_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Remember whether a sample word was taken at this edge, for the sender to see.
  always @(posedge clk) begin
    sample_taken <= rst_n && in_push && !in_full;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words outstanding",
               cycle_count, words_pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the main flow asks for one.
  initial begin
    out_pop   = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one sample word, with random idle cycles in front, until it is taken.
  task automatic send_sample(input int raw);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push       <= 1'b1;
    in_raw_sample <= SAMPLE_BITS'(raw);
    do @(negedge clk); while (!sample_taken);
    samples_sent++;
  endtask

  // Register write; the task waits with cfg_we low before it returns, so back-to-back writes do not collide.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted word has come back.
  task automatic drain_results();
    in_push <= 1'b0;
    @(negedge clk);
    while (words_pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  // New gain and deadband, weighted toward settings where the filter moves.
  task automatic pick_settings();
    int gain;
    int dband;
    case ($urandom_range(7))
      0:       gain = 0;
      1:       gain = GAIN_UNITY;
      2:       gain = GAIN_TOP;
      3:       gain = GAIN_RESET;
      4, 5:    gain = $urandom_range(4096, 1);
      6:       gain = $urandom_range(8191, 4097);
      default: gain = $urandom_range(512, 1);
    endcase
    case ($urandom_range(7))
      0:       dband = 0;
      1:       dband = FIX_TOP;
      2:       dband = DBAND_TOP;
      3, 4:    dband = $urandom_range(512);
      5:       dband = $urandom_range(4096);
      6:       dband = $urandom_range(65535);
      default: dband = DBAND_RESET;
    endcase
    cfg_write(CFG_GAIN, gain);
    cfg_write(CFG_DBAND, dband);
    if ($urandom_range(3) == 0) begin
      cfg_write($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom_range(65535));
    end
    settings_used++;
  endtask

  // Mostly a pot turned slowly, with jumps, end stops and held positions mixed in.
  function automatic int next_sample();
    int raw;
    case ($urandom_range(9))
      0, 1, 2, 3: raw = $urandom_range(SAMPLE_FULL);
      4, 5, 6, 7: raw = prev_sample + $urandom_range(40) - 20;
      8:          raw = $urandom_range(1) ? SAMPLE_FULL : 0;
      default:    raw = prev_sample;
    endcase
    if (raw < 0) begin
      raw = 0;
    end else if (raw > SAMPLE_FULL) begin
      raw = SAMPLE_FULL;
    end
    prev_sample = raw;
    return raw;
  endfunction

  initial begin
    in_push       = 1'b0;
    in_raw_sample = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_GAIN;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_req      = 0;
    samples_sent  = 0;
    settings_used = 1;
    prev_sample   = 512;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: the seeding sample at full scale, then steps and the mapping edges.
    send_sample(1023); send_sample(1023); send_sample(0); send_sample(0);
    send_sample(0); send_sample(512); send_sample(511); send_sample(1);
    send_sample(1022); send_sample(6); send_sample(5);
    drain_results();

    // Unity gain and no deadband: the drive follows the target at once.
    cfg_write(CFG_GAIN, GAIN_UNITY);
    cfg_write(CFG_DBAND, 0);
    send_sample(0); send_sample(1023); send_sample(682);
    drain_results();

    // Largest gain overshoots and must be clamped at both ends.
    cfg_write(CFG_GAIN, GAIN_TOP);
    send_sample(0); send_sample(1023); send_sample(0);
    drain_results();

    // Zero gain never moves the average.
    cfg_write(CFG_GAIN, 0);
    send_sample(1023);
    drain_results();

    // Deadband at and above full range: no step ever happens.
    cfg_write(CFG_GAIN, GAIN_UNITY);
    cfg_write(CFG_DBAND, FIX_TOP);
    send_sample(0); send_sample(1023);
    drain_results();
    cfg_write(CFG_DBAND, DBAND_TOP);
    send_sample(0);
    drain_results();

    // Writes to indexes past the register list must change nothing.
    cfg_write(CFG_DBAND, 0);
    cfg_write(CFG_SPARE_A, DBAND_TOP);
    cfg_write(CFG_SPARE_B, DBAND_TOP);
    send_sample(341);
    drain_results();
    settings_used += 6;

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct  = (phase == 1) ? 46 : (phase == 3) ? 38 : 0;
      rx_stall_pct = (phase == 2) ? 46 : (phase == 3) ? 38 : 0;
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        pick_settings();
        repeat (CHUNK_ITEMS) send_sample(next_sample());
        drain_results();
      end
    end

    // Long receiver hold-off while samples keep coming, so the input backs up.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    cfg_write(CFG_GAIN, GAIN_RESET);
    cfg_write(CFG_DBAND, DBAND_RESET);
    hold_req++;
    repeat (PRESSURE_ITEMS) send_sample(next_sample());
    drain_results();

    $display("Sent %0d samples across %0d register settings,", samples_sent, settings_used,
             " four idle mixes and one long hold-off.");
    $display("Checked %0d result words, %0d of them with a drive update.",
             words_checked, update_count);
    if (mismatch_count == 0 && words_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatching words, %0d still outstanding", mismatch_count, words_pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
